>>> rtl/sled_pkg.sv
// shared types, codes and constants for the breathing status led controller
`timescale 1ns / 1ps

package sled_pkg;

  // field widths
  localparam int unsigned PHASE_W    = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_ADDR_W = 2;

  // request opcodes
  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_SET     = 2'd1;
  localparam logic [OP_W-1:0] OP_TRIGGER = 2'd2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_IDLE_STEP  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TRACK_STEP = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BLINK_MS   = 2'd2;

  // configuration reset values
  localparam logic [STEP_W-1:0] IDLE_STEP_RST  = 16'd65;
  localparam logic [STEP_W-1:0] TRACK_STEP_RST = 16'd261;
  localparam logic [STEP_W-1:0] BLINK_MS_RST   = 16'd100;

  // fixed intensities
  localparam logic [COLOR_W-1:0] COLOR_FULL = 8'd255;
  localparam logic [COLOR_W-1:0] COLOR_OFF  = 8'd0;

  // sine table generation constants, q31
  localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;
  localparam logic [63:0] ONE_Q31     = 64'd2147483648;
  localparam int unsigned SIN_TERMS   = 8;
  localparam logic [63:0] SIN_DIV [SIN_TERMS] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  // orange mix: green is level * 50 / 255
  localparam logic [15:0] ORANGE_MUL = 16'd50;
  localparam logic [15:0] ORANGE_DIV = 16'd255;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE  = 2'd0,
    MODE_BLINK = 2'd1,
    MODE_TRACK = 2'd2,
    MODE_ERROR = 2'd3
  } sled_mode_t;

  // what the color stage shows for one tick
  typedef enum logic [2:0] {
    KIND_GREEN  = 3'd0,
    KIND_ORANGE = 3'd1,
    KIND_BLUE   = 3'd2,
    KIND_BLACK  = 3'd3,
    KIND_RED    = 3'd4
  } sled_kind_t;

  // tick result passed from the state stage to the color stage
  typedef struct packed {
    logic               valid;
    sled_kind_t         kind;
    logic [PHASE_W-1:0] phase;
  } sled_item_t;

endpackage

>>> rtl/status_led_breathing_controller_top.sv
// top level of the breathing rgb status led controller
`timescale 1ns / 1ps

// Usage: requests arrive on the in_ stream. in_tuser carries the opcode (tick,
// set mode, trigger blink); in_tdata carries the time in ms and the new mode.
// Every tick request yields one color result on the out_ stream; set mode and
// trigger requests only change state and yield nothing.
// Path: a tick passes the input register, the state stage and the output
// register before out_tvalid shows it. Throughput: one request per cycle
// while out_tready is high; the phase update (a 16x16 multiply and add) is
// done in the state stage, the sine table read in the output stage.
// The cfg_ port writes step and blink length registers; write only while idle.
// Reset: steps 65 and 261, blink length 100 ms, idle mode, phase and times
// zero, all stages empty.
// When out_tready is low the result is held, up to three requests back up in
// the stages and in_tready then drops until the receiver takes the result.
module status_led_breathing_controller_top
  import sled_pkg::*;
#(
  parameter int unsigned SINE_ENTRIES = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [STEP_W-1:0]     cfg_wdata,
  // request stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [39:0]           in_tdata,   // now_ms [31:0], new_mode [33:32], zero pad
  input  logic [OP_W-1:0]       in_tuser,   // op [1:0]
  // color stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [3*COLOR_W-1:0]  out_tdata   // red [7:0], green [15:8], blue [23:16]
);

  sled_item_t item;
  logic       item_rdy;

  // state update stage
  sled_state u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tuser),
    .in_now   (in_tdata[TIME_W-1:0]),
    .in_mode  (in_tdata[TIME_W +: MODE_W]),
    .item_o   (item),
    .item_rdy (item_rdy)
  );

  // color lookup and output register
  sled_color #(
    .SINE_ENTRIES(SINE_ENTRIES)
  ) u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_i    (item),
    .item_rdy  (item_rdy),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

>>> rtl/sled_state.sv
// input register, configuration registers and per-request state update
`timescale 1ns / 1ps

module sled_state
  import sled_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [STEP_W-1:0]     cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       in_op,
  input  logic [TIME_W-1:0]     in_now,
  input  logic [MODE_W-1:0]     in_mode,
  output sled_item_t            item_o,
  input  logic                  item_rdy
);

  // input register
  logic                s1_v_r;
  logic [OP_W-1:0]     s1_op_r;
  logic [TIME_W-1:0]   s1_now_r;
  logic [MODE_W-1:0]   s1_mode_r;

  // configuration
  logic [STEP_W-1:0]   idle_step_r;
  logic [STEP_W-1:0]   track_step_r;
  logic [STEP_W-1:0]   blink_ms_r;

  // block state
  sled_mode_t          mode_r, mode_nxt;
  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic [TIME_W-1:0]   last_r, last_nxt;
  logic [TIME_W-1:0]   bstart_r, bstart_nxt;
  sled_item_t          item_r, item_nxt;

  logic                s2_free;
  logic                s1_go;
  logic                s1_tick;
  logic [TIME_W-1:0]   elapsed;
  logic [TIME_W-1:0]   since_blink;
  logic [STEP_W-1:0]   step;
  logic [2*STEP_W-1:0] step_prod;
  logic [PHASE_W-1:0]  phase_adv;
  sled_kind_t          kind;

  // handshake between input register and state stage
  assign s1_tick  = (s1_op_r == OP_TICK);
  assign s2_free  = !item_r.valid || item_rdy;
  assign s1_go    = s1_v_r && (!s1_tick || s2_free);
  assign in_ready = !s1_v_r || s1_go;
  assign item_o   = item_r;

  // phase advance: elapsed ms (low 16 bits) times the active step
  assign elapsed     = s1_now_r - last_r;
  assign since_blink = s1_now_r - bstart_r;
  assign step        = (mode_r == MODE_TRACK) ? track_step_r : idle_step_r;
  assign step_prod   = (2*STEP_W)'(elapsed[PHASE_W-1:0]) * (2*STEP_W)'(step);
  assign phase_adv   = phase_r + step_prod[PHASE_W-1:0];

  // next state for the request in the input register
  always_comb begin
    mode_nxt   = mode_r;
    phase_nxt  = phase_r;
    last_nxt   = last_r;
    bstart_nxt = bstart_r;
    kind       = KIND_BLACK;
    item_nxt   = item_r;
    if (item_rdy) begin
      item_nxt.valid = 1'b0;
    end
    if (s1_go) begin
      case (s1_op_r)
        OP_TICK: begin
          last_nxt = s1_now_r;
          unique case (mode_r)
            MODE_IDLE: begin
              phase_nxt = phase_adv;
              kind      = KIND_GREEN;
            end
            MODE_TRACK: begin
              phase_nxt = phase_adv;
              kind      = KIND_ORANGE;
            end
            MODE_BLINK: begin
              if (since_blink < TIME_W'(blink_ms_r)) begin
                kind = KIND_BLUE;
              end else begin
                kind     = KIND_BLACK;
                mode_nxt = MODE_IDLE;
              end
            end
            MODE_ERROR: begin
              kind = KIND_RED;
            end
          endcase
          item_nxt.valid = 1'b1;
          item_nxt.kind  = kind;
          item_nxt.phase = phase_nxt;
        end
        OP_SET: begin
          mode_nxt = sled_mode_t'(s1_mode_r);
        end
        OP_TRIGGER: begin
          mode_nxt   = MODE_BLINK;
          bstart_nxt = s1_now_r;
        end
        default: begin
          // unused opcode: no state change
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_op_r   <= in_op;
      s1_now_r  <= in_now;
      s1_mode_r <= in_mode;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_step_r  <= IDLE_STEP_RST;
      track_step_r <= TRACK_STEP_RST;
      blink_ms_r   <= BLINK_MS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_IDLE_STEP:  idle_step_r  <= cfg_wdata;
        REG_TRACK_STEP: track_step_r <= cfg_wdata;
        REG_BLINK_MS:   blink_ms_r   <= cfg_wdata;
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  // block state and tick stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      phase_r    <= '0;
      last_r     <= '0;
      bstart_r   <= '0;
      item_r     <= '0;
    end else begin
      mode_r     <= mode_nxt;
      phase_r    <= phase_nxt;
      last_r     <= last_nxt;
      bstart_r   <= bstart_nxt;
      item_r     <= item_nxt;
    end
  end

  // a stalled tick stage keeps its contents
  assert property (@(posedge clk) disable iff (!rst_n)
    item_r.valid && !item_rdy |=> item_r.valid && $stable(item_r))
    else $error("tick stage lost or changed while stalled");

  // set mode takes the requested mode
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && (s1_op_r == OP_SET) |=> mode_r == sled_mode_t'($past(s1_mode_r)))
    else $error("set mode not applied");

  // trigger enters blink and records its time
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && (s1_op_r == OP_TRIGGER) |=>
      (mode_r == MODE_BLINK) && (bstart_r == $past(s1_now_r)))
    else $error("trigger not applied");

  // only ticks create a color result
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && !s1_tick && item_rdy |=> !item_r.valid)
    else $error("non-tick request produced a result");

endmodule

>>> rtl/sled_color.sv
// sine level tables and the color output register
`timescale 1ns / 1ps

module sled_color
  import sled_pkg::*;
#(
  parameter int unsigned SINE_ENTRIES = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sled_item_t           item_i,
  output logic                 item_rdy,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [3*COLOR_W-1:0] out_tdata
);

  localparam int unsigned IDX_W  = $clog2(SINE_ENTRIES);
  localparam int unsigned PROD_W = PHASE_W + IDX_W;

  // sin in q31 for x in [0, pi/2], odd taylor series
  function automatic logic [63:0] sin_q31(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x2   = (x * x) >> 31;
    term = x;
    sum  = $signed(x);
    for (int k = 0; k < SIN_TERMS; k++) begin
      term = (term * x2) >> 31;
      term = term / SIN_DIV[k];
      if ((k % 2) == 0) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > $signed(ONE_Q31)) begin
      sum = $signed(ONE_Q31);
    end
    return $unsigned(sum);
  endfunction

  // table entry: floor(255 * (sin + 1) / 2)
  function automatic logic [COLOR_W-1:0] level_of(input int unsigned i);
    logic [63:0] n;
    logic [63:0] a;
    logic [63:0] s;
    logic [63:0] v;
    logic [63:0] p;
    logic        neg;
    n   = 64'(SINE_ENTRIES);
    a   = 64'(4 * i);
    neg = 1'b0;
    if (a >= 2 * n) begin
      a   = a - 2 * n;
      neg = 1'b1;
    end
    if (a > n) begin
      a = 2 * n - a;
    end
    if (a == n) begin
      s = ONE_Q31;
    end else if (a == 0) begin
      s = '0;
    end else begin
      s = sin_q31((a * HALF_PI_Q31) / SINE_ENTRIES);
    end
    v = neg ? (ONE_Q31 - s) : (ONE_Q31 + s);
    p = (64'd255 * v) >> 32;
    return p[COLOR_W-1:0];
  endfunction

  // green share of the orange mix
  function automatic logic [COLOR_W-1:0] orange_of(input logic [COLOR_W-1:0] lvl);
    logic [15:0] q;
    q = (16'(lvl) * ORANGE_MUL) / ORANGE_DIV;
    return q[COLOR_W-1:0];
  endfunction

  logic [COLOR_W-1:0] lvl_rom [SINE_ENTRIES];
  logic [COLOR_W-1:0] org_rom [SINE_ENTRIES];

  // constant tables built at elaboration
  for (genvar gi = 0; gi < SINE_ENTRIES; gi++) begin : g_rom
    localparam logic [COLOR_W-1:0] LV = level_of(gi);
    localparam logic [COLOR_W-1:0] OG = orange_of(LV);
    assign lvl_rom[gi] = LV;
    assign org_rom[gi] = OG;
  end

  logic               out_v_r;
  logic [COLOR_W-1:0] red_r, red_nxt;
  logic [COLOR_W-1:0] green_r, green_nxt;
  logic [COLOR_W-1:0] blue_r, blue_nxt;
  logic [PROD_W-1:0]  idx_prod;
  logic [IDX_W-1:0]   idx;
  logic [COLOR_W-1:0] lvl;
  logic [COLOR_W-1:0] lvl_org;
  logic               load;

  assign item_rdy   = !out_v_r || out_tready;
  assign load       = item_i.valid && item_rdy;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {blue_r, green_r, red_r};

  // table index: floor(phase * entries / 65536)
  assign idx_prod = PROD_W'(item_i.phase) * PROD_W'(SINE_ENTRIES);
  assign idx      = idx_prod[PHASE_W +: IDX_W];
  assign lvl      = lvl_rom[idx];
  assign lvl_org  = org_rom[idx];

  // color per tick kind
  always_comb begin
    red_nxt   = COLOR_OFF;
    green_nxt = COLOR_OFF;
    blue_nxt  = COLOR_OFF;
    unique case (item_i.kind)
      KIND_GREEN: begin
        green_nxt = lvl;
      end
      KIND_ORANGE: begin
        red_nxt   = lvl;
        green_nxt = lvl_org;
      end
      KIND_BLUE: begin
        blue_nxt = COLOR_FULL;
      end
      KIND_RED: begin
        red_nxt = COLOR_FULL;
      end
      default: begin
        // black
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (item_rdy) begin
      out_v_r <= item_i.valid;
    end
    if (load) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  // a loaded tick is presented on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_tvalid)
    else $error("loaded tick not presented");

  // error mode shows solid red
  assert property (@(posedge clk) disable iff (!rst_n)
    load && (item_i.kind == KIND_RED) |=>
      (red_r == COLOR_FULL) && (green_r == COLOR_OFF) && (blue_r == COLOR_OFF))
    else $error("error color wrong");

  // idle breathing never lights red or blue
  assert property (@(posedge clk) disable iff (!rst_n)
    load && (item_i.kind == KIND_GREEN) |=>
      (red_r == COLOR_OFF) && (blue_r == COLOR_OFF))
    else $error("idle color wrong");

endmodule
